FILE: rtl/unicode_range_list_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Unicode-range list parser assertion macros
// Assertion macros used by the RTL of the unicode-range list parser.
// Each macro expects a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef UNICODE_RANGE_LIST_PARSER_CORE_MACROS_SVH
`define UNICODE_RANGE_LIST_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URLP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define URLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/urlp_pkg.sv
// ----------------------------------------------------------------------------
// Unicode-range list parser package
// Request and result types, parse phases, character codes and the helper
// functions that classify one byte of the list text.
// ----------------------------------------------------------------------------
package urlp_pkg;

    // Widths and limits.
    localparam int unsigned ACC_W      = 24;
    localparam int unsigned CP_W       = 21;
    localparam int unsigned CNT_W      = 3;
    localparam logic [CNT_W-1:0] MAX_DIGITS = 3'd6;
    localparam logic [ACC_W-1:0] CP_MAX     = 24'h10FFFF;
    localparam logic [3:0]       NIBBLE_F   = 4'hF;

    // Character codes of the grammar.
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_UPPER_U = 8'h55;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Parse phases of one part.
    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_GOTU  = 3'd1,
        PH_START = 3'd2,
        PH_END   = 3'd3,
        PH_TRAIL = 3'd4
    } urlp_phase_t;

    // One request: a byte of the list and its end flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       last_char;
    } urlp_in_t;

    // One result: a closed part of the list.
    typedef struct packed {
        logic            part_valid;
        logic [CP_W-1:0] range_low;
        logic [CP_W-1:0] range_high;
        logic            last_part;
    } urlp_out_t;

    // Decoded hex digit with a flag that the byte is one.
    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } urlp_hex_t;

    // ASCII whitespace: space, tab, LF, VT, FF and CR.
    function automatic logic urlp_is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Hex digit decode for 0-9, a-f and A-F.
    function automatic urlp_hex_t urlp_hex(input logic [7:0] c);
        urlp_hex_t r;
        r.is_hex = 1'b1;
        r.value  = 4'h0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            r.value = c[3:0];
        end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
            r.value = c[3:0] + 4'd9;
        end else begin
            r.is_hex = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: rtl/unicode_range_list_parser_core.sv
// An accepted request goes into the input register, then the parse logic writes
// the result of a part-closing byte into the result register.
// Throughput: one byte per cycle, except where a stall holds the stage.
// Only a closing byte waits while the result register holds an untaken result.
// Reset (rst_n low, asynchronous) empties both registers and returns the part
// state to the leading-whitespace phase with all accumulators cleared.
// ----------------------------------------------------------------------------
// Unicode-range list parser core
// Parses a comma-separated unicode-range list one byte per cycle while no closing byte stalls,
// and emits one result per closed part with its validity and low and high code points.
// ----------------------------------------------------------------------------
`include "unicode_range_list_parser_core_macros.svh"

module unicode_range_list_parser_core
    import urlp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  urlp_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output urlp_out_t out_data
);

    // Input register.
    logic     in_valid_reg, in_valid_next;
    urlp_in_t in_data_reg;

    // Part state.
    urlp_phase_t      phase_reg, phase_next;
    logic [ACC_W-1:0] low_acc_reg, low_acc_next;
    logic [ACC_W-1:0] high_acc_reg, high_acc_next;
    logic [ACC_W-1:0] end_acc_reg, end_acc_next;
    logic [CNT_W-1:0] digit_count_reg, digit_count_next;
    logic [CNT_W-1:0] end_digit_count_reg, end_digit_count_next;
    logic             wildcard_seen_reg, wildcard_seen_next;
    logic             part_error_reg, part_error_next;

    // Result register.
    logic      out_valid_reg, out_valid_next;
    urlp_out_t out_data_reg, out_data_next;

    // State after the current byte is taken, before any close.
    urlp_phase_t      tk_phase;
    logic [ACC_W-1:0] tk_low, tk_high, tk_end;
    logic [CNT_W-1:0] tk_dc, tk_edc;
    logic             tk_wild, tk_err;

    logic             closes;
    logic             advance;
    logic [7:0]       c;
    urlp_hex_t        hx;
    logic             ws;
    logic             ok;
    logic [ACC_W-1:0] hi_sel;

    assign c      = in_data_reg.ch;
    assign hx     = urlp_hex(c);
    assign ws     = urlp_is_ws(c);
    assign closes = (c == CH_COMMA) || in_data_reg.last_char;

    // The stage moves on unless a closing byte meets an untaken result.
    assign advance  = in_valid_reg && (!closes || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Take one byte into the part state, following the grammar of the phase.
    always_comb
    begin
        tk_phase = phase_reg;
        tk_low   = low_acc_reg;
        tk_high  = high_acc_reg;
        tk_end   = end_acc_reg;
        tk_dc    = digit_count_reg;
        tk_edc   = end_digit_count_reg;
        tk_wild  = wildcard_seen_reg;
        tk_err   = part_error_reg;
        if ((c != CH_COMMA) && !part_error_reg)
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if ((c == CH_UPPER_U) || (c == CH_LOWER_U))
                    begin
                        tk_phase = PH_GOTU;
                    end
                    else if (!ws)
                    begin
                        tk_err = 1'b1;
                    end
                end
                PH_GOTU:
                begin
                    if (c == CH_PLUS)
                    begin
                        tk_phase = PH_START;
                    end
                    else
                    begin
                        tk_err = 1'b1;
                    end
                end
                PH_START:
                begin
                    if (hx.is_hex)
                    begin
                        if (wildcard_seen_reg || (digit_count_reg >= MAX_DIGITS))
                        begin
                            tk_err = 1'b1;
                        end
                        else
                        begin
                            tk_low  = {low_acc_reg[ACC_W-5:0], hx.value};
                            tk_high = {high_acc_reg[ACC_W-5:0], hx.value};
                            tk_dc   = digit_count_reg + 3'd1;
                        end
                    end
                    else if (c == CH_QMARK)
                    begin
                        if (digit_count_reg >= MAX_DIGITS)
                        begin
                            tk_err = 1'b1;
                        end
                        else
                        begin
                            tk_wild = 1'b1;
                            tk_low  = {low_acc_reg[ACC_W-5:0], 4'h0};
                            tk_high = {high_acc_reg[ACC_W-5:0], NIBBLE_F};
                            tk_dc   = digit_count_reg + 3'd1;
                        end
                    end
                    else if (c == CH_DASH)
                    begin
                        if (wildcard_seen_reg || (digit_count_reg == '0))
                        begin
                            tk_err = 1'b1;
                        end
                        else
                        begin
                            tk_phase = PH_END;
                        end
                    end
                    else if (ws)
                    begin
                        // Leaving the digits: at least one must have come.
                        if (digit_count_reg == '0)
                        begin
                            tk_err = 1'b1;
                        end
                        tk_phase = PH_TRAIL;
                    end
                    else
                    begin
                        tk_err = 1'b1;
                    end
                end
                PH_END:
                begin
                    if (hx.is_hex)
                    begin
                        if (end_digit_count_reg >= MAX_DIGITS)
                        begin
                            tk_err = 1'b1;
                        end
                        else
                        begin
                            tk_end = {end_acc_reg[ACC_W-5:0], hx.value};
                            tk_edc = end_digit_count_reg + 3'd1;
                        end
                    end
                    else if (ws)
                    begin
                        if (end_digit_count_reg == '0)
                        begin
                            tk_err = 1'b1;
                        end
                        tk_phase = PH_TRAIL;
                    end
                    else
                    begin
                        tk_err = 1'b1;
                    end
                end
                default:
                begin
                    if (!ws)
                    begin
                        tk_err = 1'b1;
                    end
                end
            endcase
        end
    end

    // Next part state: cleared after a close, else the taken state.
    always_comb
    begin
        phase_next           = phase_reg;
        low_acc_next         = low_acc_reg;
        high_acc_next        = high_acc_reg;
        end_acc_next         = end_acc_reg;
        digit_count_next     = digit_count_reg;
        end_digit_count_next = end_digit_count_reg;
        wildcard_seen_next   = wildcard_seen_reg;
        part_error_next      = part_error_reg;
        if (advance && closes)
        begin
            phase_next           = PH_LEAD;
            low_acc_next         = '0;
            high_acc_next        = '0;
            end_acc_next         = '0;
            digit_count_next     = '0;
            end_digit_count_next = '0;
            wildcard_seen_next   = 1'b0;
            part_error_next      = 1'b0;
        end
        else if (advance)
        begin
            phase_next           = tk_phase;
            low_acc_next         = tk_low;
            high_acc_next        = tk_high;
            end_acc_next         = tk_end;
            digit_count_next     = tk_dc;
            end_digit_count_next = tk_edc;
            wildcard_seen_next   = tk_wild;
            part_error_next      = tk_err;
        end
    end

    // Result of the part closed by this byte, with bound checks and clamp.
    always_comb
    begin
        hi_sel = (tk_edc != '0) ? tk_end : tk_high;
        ok = !tk_err && (tk_dc != '0) &&
             ((tk_phase == PH_START) || (tk_phase == PH_END) || (tk_phase == PH_TRAIL));
        if ((tk_phase == PH_END) && (tk_edc == '0))
        begin
            ok = 1'b0;
        end
        if ((tk_low > hi_sel) || (tk_low > CP_MAX))
        begin
            ok = 1'b0;
        end
        out_data_next.part_valid = ok;
        out_data_next.last_part  = in_data_reg.last_char;
        out_data_next.range_low  = ok ? tk_low[CP_W-1:0] : '0;
        if (!ok)
        begin
            out_data_next.range_high = '0;
        end
        else if (hi_sel > CP_MAX)
        begin
            out_data_next.range_high = CP_MAX[CP_W-1:0];
        end
        else
        begin
            out_data_next.range_high = hi_sel[CP_W-1:0];
        end
    end

    // Handshake bookkeeping of both registers.
    assign in_valid_next  = (in_valid && in_ready) || (in_valid_reg && !advance);
    assign out_valid_next = (out_valid_reg && !out_ready) || (advance && closes);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            phase_reg           <= PH_LEAD;
            low_acc_reg         <= '0;
            high_acc_reg        <= '0;
            end_acc_reg         <= '0;
            digit_count_reg     <= '0;
            end_digit_count_reg <= '0;
            wildcard_seen_reg   <= 1'b0;
            part_error_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg        <= in_valid_next;
            out_valid_reg       <= out_valid_next;
            phase_reg           <= phase_next;
            low_acc_reg         <= low_acc_next;
            high_acc_reg        <= high_acc_next;
            end_acc_reg         <= end_acc_next;
            digit_count_reg     <= digit_count_next;
            end_digit_count_reg <= end_digit_count_next;
            wildcard_seen_reg   <= wildcard_seen_next;
            part_error_reg      <= part_error_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance && closes)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Assertions.
    `URLP_ASSERT_SAME(a_invalid_zero, out_valid_reg && !out_data_reg.part_valid,
        (out_data_reg.range_low == '0) && (out_data_reg.range_high == '0),
        "invalid part carries a nonzero range")
    `URLP_ASSERT_SAME(a_valid_order, out_valid_reg && out_data_reg.part_valid,
        (out_data_reg.range_low <= out_data_reg.range_high) &&
        ({3'b000, out_data_reg.range_high} <= CP_MAX),
        "valid part has low above high or high above the code point limit")
    `URLP_ASSERT_NEXT(a_close_clears, advance && closes,
        (phase_reg == PH_LEAD) && (digit_count_reg == '0) && !part_error_reg,
        "part state not cleared after a close")
    `URLP_ASSERT_SAME(a_count_limit, 1'b1,
        (digit_count_reg <= MAX_DIGITS) && (end_digit_count_reg <= MAX_DIGITS),
        "digit count beyond the limit")

endmodule

FILE: tb/unicode_range_list_parser_core_checker.sv
// ----------------------------------------------------------------------------
// Unicode-range list parser checker
// Watches both channels of the parser, follows the part grammar byte by byte
// to work out the expected result of every closed part, and compares each
// result the block hands out against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module unicode_range_list_parser_core_checker
    import urlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  urlp_in_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  urlp_out_t   out_data,
    output int unsigned error_count,
    output int unsigned parts_pending
);

    // Parse state of the part being read.
    urlp_phase_t      ph;
    logic [ACC_W-1:0] lo_acc;
    logic [ACC_W-1:0] hi_acc;
    logic [ACC_W-1:0] end_val;
    logic [CNT_W-1:0] n_digits;
    logic [CNT_W-1:0] n_end_digits;
    logic             wild;
    logic             bad;

    // Results still owed by the block, oldest first.
    urlp_out_t expected_parts[$];

    initial
    begin
        error_count   = 0;
        parts_pending = 0;
    end

    // Space, tab and the line-control characters up to CR count as whitespace.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Value of a hex digit, or -1 for any other byte.
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    task automatic clear_part();
        ph           = PH_LEAD;
        lo_acc       = '0;
        hi_acc       = '0;
        end_val      = '0;
        n_digits     = '0;
        n_end_digits = '0;
        wild         = 1'b0;
        bad          = 1'b0;
    endtask

    // Whitespace after the digits: the part must already be complete.
    task automatic to_trail();
        if (ph == PH_GOTU || (ph == PH_START && n_digits == 0) ||
            (ph == PH_END && n_end_digits == 0))
            bad = 1'b1;
        ph = PH_TRAIL;
    endtask

    // Advance the grammar by one byte that is not a comma.
    task automatic take_byte(input logic [7:0] c);
        int         h;
        logic [3:0] nib;
        h   = hex_digit(c);
        nib = h[3:0];
        if (bad)
            return;
        case (ph)
            PH_LEAD:
            begin
                if (c == CH_UPPER_U || c == CH_LOWER_U)
                    ph = PH_GOTU;
                else if (!is_space(c))
                    bad = 1'b1;
            end
            PH_GOTU:
            begin
                if (c == CH_PLUS)
                    ph = PH_START;
                else
                    bad = 1'b1;
            end
            PH_START:
            begin
                if (h >= 0)
                begin
                    if (wild || n_digits >= MAX_DIGITS)
                        bad = 1'b1;
                    else
                    begin
                        lo_acc   = {lo_acc[ACC_W-5:0], nib};
                        hi_acc   = {hi_acc[ACC_W-5:0], nib};
                        n_digits = n_digits + 1'b1;
                    end
                end
                else if (c == CH_QMARK)
                begin
                    if (n_digits >= MAX_DIGITS)
                        bad = 1'b1;
                    else
                    begin
                        wild     = 1'b1;
                        lo_acc   = {lo_acc[ACC_W-5:0], 4'h0};
                        hi_acc   = {hi_acc[ACC_W-5:0], NIBBLE_F};
                        n_digits = n_digits + 1'b1;
                    end
                end
                else if (c == CH_DASH)
                begin
                    if (wild || n_digits == 0)
                        bad = 1'b1;
                    else
                        ph = PH_END;
                end
                else if (is_space(c))
                    to_trail();
                else
                    bad = 1'b1;
            end
            PH_END:
            begin
                if (h >= 0)
                begin
                    if (n_end_digits >= MAX_DIGITS)
                        bad = 1'b1;
                    else
                    begin
                        end_val      = {end_val[ACC_W-5:0], nib};
                        n_end_digits = n_end_digits + 1'b1;
                    end
                end
                else if (is_space(c))
                    to_trail();
                else
                    bad = 1'b1;
            end
            default:
            begin
                if (!is_space(c))
                    bad = 1'b1;
            end
        endcase
    endtask

    // Take one accepted request; a comma or the last byte closes the part.
    task automatic predict_request(input urlp_in_t req);
        logic             ok;
        logic [ACC_W-1:0] lo;
        logic [ACC_W-1:0] hi;
        urlp_out_t        part;
        if (req.ch != CH_COMMA)
            take_byte(req.ch);
        if (req.ch == CH_COMMA || req.last_char)
        begin
            ok = !bad && n_digits != 0 &&
                 (ph == PH_START || ph == PH_END || ph == PH_TRAIL);
            if (ok && ph == PH_END && n_end_digits == 0)
                ok = 1'b0;
            lo = lo_acc;
            hi = (n_end_digits != 0) ? end_val : hi_acc;
            if (ok && (lo > hi || lo > CP_MAX))
                ok = 1'b0;
            if (hi > CP_MAX)
                hi = CP_MAX;
            if (!ok)
            begin
                lo = '0;
                hi = '0;
            end
            part.part_valid = ok;
            part.range_low  = lo[CP_W-1:0];
            part.range_high = hi[CP_W-1:0];
            part.last_part  = req.last_char;
            expected_parts.push_back(part);
            clear_part();
        end
    endtask

    task automatic flag_field(input string field, input logic [23:0] want,
                              input logic [23:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        error_count++;
    endtask

    // Requests are predicted before results are compared at the same edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        urlp_out_t want;
        if (!rst_n)
        begin
            clear_part();
            expected_parts.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                predict_request(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_parts.size() == 0)
                begin
                    $display("%0t: result with none expected, expected nothing, got %p",
                             $time, out_data);
                    error_count++;
                end
                else
                begin
                    want = expected_parts.pop_front();
                    if (out_data.part_valid !== want.part_valid)
                        flag_field("part_valid", 24'(want.part_valid),
                                   24'(out_data.part_valid));
                    if (out_data.range_low !== want.range_low)
                        flag_field("range_low", 24'(want.range_low),
                                   24'(out_data.range_low));
                    if (out_data.range_high !== want.range_high)
                        flag_field("range_high", 24'(want.range_high),
                                   24'(out_data.range_high));
                    if (out_data.last_part !== want.last_part)
                        flag_field("last_part", 24'(want.last_part),
                                   24'(out_data.last_part));
                end
            end
        end
        parts_pending = expected_parts.size();
    end

endmodule

FILE: tb/unicode_range_list_parser_core_tb.sv
// ----------------------------------------------------------------------------
// Unicode-range list parser testbench
// Feeds the parser a short set of hand-picked lists, then about a thousand
// bytes of random lists made mostly of well-formed parts with some broken
// parts and noise, with random gaps and stalls on both channels and one long
// result stall. A checker beside the parser predicts and compares the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module unicode_range_list_parser_core_tb
    import urlp_pkg::*;
();

    localparam int         RANDOM_BYTES = 1000;
    localparam int         CALM_TAIL    = 150;
    localparam int         HOLD_AT      = 400;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    urlp_in_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    urlp_out_t   out_data;
    int unsigned error_count;
    int unsigned parts_pending;

    // Bytes of all lists in the order they are sent.
    urlp_in_t text_q[$];

    bit quiet_tail  = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;
    bit hold_done   = 1'b0;
    int idle_cycles = 0;

    unicode_range_list_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    unicode_range_list_parser_core_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .error_count   (error_count),
        .parts_pending (parts_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] c);
        text_q.push_back('{ch: c, last_char: 1'b0});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic mark_last();
        text_q[text_q.size() - 1].last_char = 1'b1;
    endtask

    task automatic push_ws();
        case ($urandom_range(0, 5))
            0: push_byte(CH_SPACE);
            1: push_byte(CH_TAB);
            2: push_byte(CH_LF);
            3: push_byte(CH_VT);
            4: push_byte(CH_FF);
            default: push_byte(CH_CR);
        endcase
    endtask

    // Low n nibbles of v as hex digits in mixed case.
    task automatic push_hex(input logic [31:0] v, input int n);
        logic [3:0] nib;
        for (int d = n - 1; d >= 0; d--)
        begin
            nib = 4'((v >> (4 * d)) & 32'hF);
            if (nib < 10)
                push_byte("0" + nib);
            else if ($urandom_range(0, 1) == 1)
                push_byte(8'("a" + nib - 10));
            else
                push_byte(8'("A" + nib - 10));
        end
    endtask

    // The value in as few digits as it needs, sometimes padded with zeros.
    task automatic push_code(input logic [31:0] v);
        int n;
        n = 1;
        while (n < 6 && (v >> (4 * n)) != 0)
            n++;
        if ($urandom_range(0, 1) == 1)
            n = $urandom_range(n, 6);
        push_hex(v, n);
    endtask

    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'(CP_MAX);
            2: return 32'(CP_MAX) + 32'd1;
            3: return 32'hFFFFFF;
            4: return $urandom_range(0, 255);
            default: return $urandom_range(0, CP_MAX);
        endcase
    endfunction

    // A byte that is likely to matter to the grammar, or any byte at all.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return 8'("0" + $urandom_range(0, 9));
            1: return CH_DASH;
            2: return CH_QMARK;
            3: return CH_SPACE;
            4: return CH_PLUS;
            5: return CH_UPPER_U;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One well-formed part: a single code point, a wildcard mask or a range.
    task automatic make_well_formed();
        logic [31:0] lo;
        logic [31:0] hi;
        int          n_wild;
        repeat ($urandom_range(0, 2)) push_ws();
        push_byte(($urandom_range(0, 1) == 1) ? CH_UPPER_U : CH_LOWER_U);
        push_byte(CH_PLUS);
        lo = pick_code();
        case ($urandom_range(0, 2))
            0: push_code(lo);
            1:
            begin
                n_wild = $urandom_range(1, 6);
                push_hex(lo, $urandom_range(0, 6 - n_wild));
                repeat (n_wild) push_byte(CH_QMARK);
            end
            default:
            begin
                push_code(lo);
                push_byte(CH_DASH);
                if ($urandom_range(0, 1) == 1)
                    hi = lo + $urandom_range(0, 4095);
                else
                    hi = pick_code();
                push_code(hi);
            end
        endcase
        repeat ($urandom_range(0, 2)) push_ws();
    endtask

    // Random lists of one to five parts; most parts are well formed.
    task automatic build_random_lists(input int target);
        int list_start;
        int part_start;
        int pos;
        while (text_q.size() < target)
        begin
            list_start = text_q.size();
            for (int p = $urandom_range(1, 5); p > 0; p--)
            begin
                if (text_q.size() != list_start)
                    push_byte(CH_COMMA);
                part_start = text_q.size();
                case ($urandom_range(0, 9))
                    7, 8:
                    begin
                        // Broken part: one byte replaced, inserted or dropped.
                        make_well_formed();
                        pos = $urandom_range(part_start, text_q.size() - 1);
                        case ($urandom_range(0, 2))
                            0: text_q[pos].ch = 8'($urandom_range(0, 255));
                            1: text_q.insert(pos, '{ch: noise_byte(), last_char: 1'b0});
                            default: text_q.delete(pos);
                        endcase
                    end
                    9: repeat ($urandom_range(0, 6)) push_byte(noise_byte());
                    default: make_well_formed();
                endcase
            end
            if (text_q.size() == list_start || $urandom_range(0, 2) == 0)
                push_byte(CH_COMMA);
            mark_last();
        end
    endtask

    // Sender: one request per accepted byte, gaps in random bursts.
    initial
    begin : stimulus
        int gap;
        int idle_odds;
        idle_odds = 0;

        // Whitespace around a range, a clamped wildcard, a start above the
        // code space closed by a comma on the last byte, then a stray byte
        // that starts and ends a list of its own.
        push_text(" U+0-F\t,");
        push_text("u+1?????,");
        push_text("U+110000,");
        mark_last();
        push_byte(8'hFF);
        mark_last();
        build_random_lists(text_q.size() + RANDOM_BYTES);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < text_q.size(); i++)
        begin
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: idle_odds = 0;
                    1: idle_odds = 8;
                    default: idle_odds = 3;
                endcase
            end
            if (i == text_q.size() - CALM_TAIL)
                quiet_tail = 1'b1;
            if (i == HOLD_AT)
                hold_req = 1'b1;
            if (!quiet_tail && !hold_active && idle_odds != 0 &&
                $urandom_range(1, idle_odds) == 1)
            begin
                in_valid <= 1'b0;
                gap = $urandom_range(1, 14);
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= text_q[i];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            @(negedge clk);
        end
        in_valid <= 1'b0;

        wait (parts_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, none in the final stretch.
    initial
    begin : receiver
        int span;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_active = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
                out_ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                span = $urandom_range(1, 14);
                repeat (span - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                span = $urandom_range(1, 24);
                repeat (span - 1) @(negedge clk);
            end
        end
    end

endmodule
